// ----- rtl/fdc_pkg.sv -----
// Package for the frame duration calculator: microcode format, program and shared types.
package fdc_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned PcW   = 4;

  localparam logic [WordW-1:0] TICK_RATE  = 32'd90000;
  localparam logic [WordW-1:0] SCALE_STEP = 32'd10;
  localparam logic [WordW-1:0] FULL_WORD  = 32'hFFFF_FFFF;

  // Divide by ten as (a * RECIP_TEN) >> RecipShift, exact for any 32-bit a
  localparam logic [WordW-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam int unsigned      RecipShift = 35;

  // Dividend select
  typedef enum logic [2:0] {
    SRC_X, SRC_TICK, SRC_NUM, SRC_FULL, SRC_D, SRC_K, SRC_R, SRC_P
  } a_src_t;

  // Divisor select
  typedef enum logic [2:0] {
    DVS_Y, DVS_X, DVS_K, DVS_R
  } b_src_t;

  // Divider result destination
  typedef enum logic [2:0] {
    DST_GCD, DST_K, DST_R, DST_BOUND, DST_D, DST_P
  } dst_t;

  // Non-divide operation of a step
  typedef enum logic [2:0] {
    MISC_NONE, MISC_INIT, MISC_MUL, MISC_EMIT, MISC_EMIT_INV, MISC_DIV10
  } misc_t;

  // Jump condition, evaluated when the step completes
  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_IN_ZERO, COND_Y_NZ, COND_K_ZERO,
    COND_D_LE_BOUND, COND_R_ZERO
  } cond_t;

  typedef struct packed {
    logic           is_div;
    a_src_t         a;
    b_src_t         b;
    dst_t           dst;
    misc_t          misc;
    cond_t          cond;
    logic [PcW-1:0] target;
  } ucw_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_zero;
    logic y_nz;
    logic k_zero;
    logic d_le_bound;
    logic r_zero;
    logic div_done;
    logic div_busy;
    logic out_free;
  } fdc_stat_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    ucw_t ucw;
    logic step_go;
    logic div_start;
  } fdc_ctrl_t;

  typedef enum logic {ST_IDLE, ST_RUN} seq_state_t;

  // Program addresses
  localparam logic [PcW-1:0] PC_START    = 4'd0;
  localparam logic [PcW-1:0] PC_GCD_DIV  = 4'd1;
  localparam logic [PcW-1:0] PC_GCD_TST  = 4'd2;
  localparam logic [PcW-1:0] PC_K        = 4'd3;
  localparam logic [PcW-1:0] PC_R        = 4'd4;
  localparam logic [PcW-1:0] PC_BOUND    = 4'd5;
  localparam logic [PcW-1:0] PC_SC_KTST  = 4'd6;
  localparam logic [PcW-1:0] PC_SC_DTST  = 4'd7;
  localparam logic [PcW-1:0] PC_SC_D     = 4'd8;
  localparam logic [PcW-1:0] PC_SC_K     = 4'd9;
  localparam logic [PcW-1:0] PC_SC_R     = 4'd10;
  localparam logic [PcW-1:0] PC_MUL      = 4'd11;
  localparam logic [PcW-1:0] PC_QUOT     = 4'd12;
  localparam logic [PcW-1:0] PC_EMIT     = 4'd13;
  localparam logic [PcW-1:0] PC_EMIT_INV = 4'd14;

  // Microcode ROM
  function automatic ucw_t ucode_word(input logic [PcW-1:0] pc);
    ucw_t w;
    w = '{is_div: 1'b0, a: SRC_X, b: DVS_Y, dst: DST_P, misc: MISC_NONE,
          cond: COND_NEVER, target: PC_START};
    case (pc)
      PC_START: begin
        w.misc = MISC_INIT; w.cond = COND_IN_ZERO; w.target = PC_EMIT_INV;
      end
      PC_GCD_DIV: begin
        w.is_div = 1'b1; w.a = SRC_X; w.b = DVS_Y; w.dst = DST_GCD;
      end
      PC_GCD_TST: begin
        w.cond = COND_Y_NZ; w.target = PC_GCD_DIV;
      end
      PC_K: begin
        w.is_div = 1'b1; w.a = SRC_TICK; w.b = DVS_X; w.dst = DST_K;
      end
      PC_R: begin
        w.is_div = 1'b1; w.a = SRC_NUM; w.b = DVS_X; w.dst = DST_R;
      end
      PC_BOUND: begin
        w.is_div = 1'b1; w.a = SRC_FULL; w.b = DVS_K; w.dst = DST_BOUND;
      end
      PC_SC_KTST: begin
        w.cond = COND_K_ZERO; w.target = PC_MUL;
      end
      PC_SC_DTST: begin
        w.cond = COND_D_LE_BOUND; w.target = PC_MUL;
      end
      PC_SC_D: begin
        w.misc = MISC_DIV10; w.a = SRC_D; w.dst = DST_D;
      end
      PC_SC_K: begin
        w.misc = MISC_DIV10; w.a = SRC_K; w.dst = DST_K;
      end
      PC_SC_R: begin
        w.misc = MISC_DIV10; w.a = SRC_R; w.dst = DST_R;
        w.cond = COND_ALWAYS; w.target = PC_SC_KTST;
      end
      PC_MUL: begin
        w.misc = MISC_MUL; w.cond = COND_R_ZERO; w.target = PC_EMIT_INV;
      end
      PC_QUOT: begin
        w.is_div = 1'b1; w.a = SRC_P; w.b = DVS_R; w.dst = DST_P;
      end
      PC_EMIT: begin
        w.misc = MISC_EMIT;
      end
      default: begin
        w.misc = MISC_EMIT_INV;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/fdc_req_if.sv -----
// Request channel: frame rate numerator and denominator.
interface fdc_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] rate_numerator;
  logic [31:0] rate_denominator;

  modport source(output valid, output rate_numerator, output rate_denominator, input ready);
  modport sink(input valid, input rate_numerator, input rate_denominator, output ready);
endinterface

// ----- rtl/fdc_rsp_if.sv -----
// Result channel: frame duration in 90 kHz ticks and invalid flag.
interface fdc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] duration_ticks;
  logic        invalid;

  modport source(output valid, output duration_ticks, output invalid, input ready);
  modport sink(input valid, input duration_ticks, input invalid, output ready);
endinterface

// ----- rtl/fdc_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module fdc_div
  import fdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WordW-1:0] dividend,
  input  logic [WordW-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [WordW-1:0] quo,
  output logic [WordW-1:0] rem
);

  localparam int unsigned CntW = $clog2(WordW);

  logic [WordW-1:0] dvs;
  logic [CntW-1:0]  cnt;
  logic [WordW:0]   rem_shift;
  logic [WordW:0]   diff;

  // Shift in next dividend bit and trial subtract
  assign rem_shift = {rem, quo[WordW-1]};
  assign diff      = rem_shift - {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(WordW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[WordW]) begin
        rem <= diff[WordW-1:0];
        quo <= {quo[WordW-2:0], 1'b1};
      end else begin
        rem <= rem_shift[WordW-1:0];
        quo <= {quo[WordW-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/fdc_seq.sv -----
// Microcode sequencer: step counter, ROM lookup, jump logic and divider handshake.
module fdc_seq
  import fdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  fdc_stat_t stat,
  output fdc_ctrl_t ctrl
);

  seq_state_t     state, state_next;
  logic [PcW-1:0] pc, pc_next;
  logic           issued;
  logic           taken;
  logic           is_emit;
  ucw_t           ucw;

  assign ucw     = ucode_word(pc);
  assign is_emit = (ucw.misc == MISC_EMIT) || (ucw.misc == MISC_EMIT_INV);

  // Jump condition
  always_comb begin
    unique case (ucw.cond)
      COND_ALWAYS:     taken = 1'b1;
      COND_IN_ZERO:    taken = stat.in_zero;
      COND_Y_NZ:       taken = stat.y_nz;
      COND_K_ZERO:     taken = stat.k_zero;
      COND_D_LE_BOUND: taken = stat.d_le_bound;
      COND_R_ZERO:     taken = stat.r_zero;
      default:         taken = 1'b0;
    endcase
  end

  // Next state, step counter and commands
  always_comb begin
    state_next     = state;
    pc_next        = pc;
    in_ready       = 1'b0;
    ctrl.ucw       = ucw;
    ctrl.step_go   = 1'b0;
    ctrl.div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_RUN;
          pc_next    = PC_START;
        end
      end
      ST_RUN: begin
        if (ucw.is_div) begin
          ctrl.div_start = !issued;
          ctrl.step_go   = stat.div_done;
        end else if (is_emit) begin
          ctrl.step_go = stat.out_free;
        end else begin
          ctrl.step_go = 1'b1;
        end
        if (ctrl.step_go) begin
          if (is_emit) begin
            state_next = ST_IDLE;
          end else begin
            pc_next = taken ? ucw.target : pc + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pc     <= PC_START;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (ctrl.div_start) begin
        issued <= 1'b1;
      end else if (stat.div_done) begin
        issued <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/frame_duration_calc.sv -----
// Frame duration calculator top level: datapath registers, divider and sequencer.
//
// Converts a frame rate (numerator / denominator) into the frame duration in
// 90 kHz ticks. One request on req gives exactly one result on rsp.
// A request is taken only while the block is idle; a finished result sits in
// an output register, so the next request is taken while it waits.
// A small microprogram drives one shared serial divider and one 32x32
// multiplier, which also divides by ten through a reciprocal. Each divide
// step waits for the divider to finish. A zero input goes straight from the
// first step to the invalid result; otherwise the run grows with each Euclid
// step and each scaling round by 10.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register; no other state survives between requests.
// When the receiver stalls, the result holds in rsp and the sequencer waits
// at its final step until the output register is free.
// rsp.invalid is set, with duration 0, for a zero input or a numerator that
// scales down to zero.
module frame_duration_calc
  import fdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  fdc_req_if.sink   req,
  fdc_rsp_if.source rsp
);

  fdc_stat_t stat;
  fdc_ctrl_t ctrl;
  ucw_t      ucw;

  logic [WordW-1:0] num, den, x, y, k, r, bound, d, p;
  logic [WordW-1:0] div_a, div_b, div_quo, div_rem;
  logic [WordW-1:0] mul_a, mul_b, quo_ten;
  logic [2*WordW-1:0] prod;
  logic             div_busy, div_done;
  logic             load;

  assign ucw  = ctrl.ucw;
  assign load = req.valid && req.ready;

  fdc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Operand select for the shared divider
  always_comb begin
    unique case (ucw.a)
      SRC_X:    div_a = x;
      SRC_TICK: div_a = TICK_RATE;
      SRC_NUM:  div_a = num;
      SRC_FULL: div_a = FULL_WORD;
      SRC_D:    div_a = d;
      SRC_K:    div_a = k;
      SRC_R:    div_a = r;
      SRC_P:    div_a = p;
      default:  div_a = x;
    endcase
    unique case (ucw.b)
      DVS_Y:   div_b = y;
      DVS_X:   div_b = x;
      DVS_K:   div_b = k;
      DVS_R:   div_b = r;
      default: div_b = y;
    endcase
  end

  fdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Shared multiplier: k * den for the product, reciprocal multiply for a divide by ten
  always_comb begin
    if (ucw.misc == MISC_MUL) begin
      mul_a = k;
      mul_b = den;
    end else begin
      mul_a = div_a;
      mul_b = RECIP_TEN;
    end
  end

  assign prod    = (2*WordW)'(mul_a) * (2*WordW)'(mul_b);
  assign quo_ten = WordW'(prod >> RecipShift);

  // Status back to the sequencer
  always_comb begin
    stat.in_zero    = (num == '0) || (den == '0);
    stat.y_nz       = (y != '0);
    stat.k_zero     = (k == '0);
    stat.d_le_bound = (d <= bound);
    stat.r_zero     = (r == '0);
    stat.div_done   = div_done;
    stat.div_busy   = div_busy;
    stat.out_free   = !rsp.valid || rsp.ready;
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (load) begin
      num <= req.rate_numerator;
      den <= req.rate_denominator;
    end
    if (ctrl.step_go) begin
      if (ucw.is_div) begin
        unique case (ucw.dst)
          DST_GCD: begin
            x <= y;
            y <= div_rem;
          end
          DST_K:     k     <= div_quo;
          DST_R:     r     <= div_quo;
          DST_BOUND: bound <= div_quo;
          DST_D:     d     <= div_quo;
          DST_P:     p     <= div_quo;
          default:   p     <= div_quo;
        endcase
      end else if (ucw.misc == MISC_INIT) begin
        x <= TICK_RATE;
        y <= num;
        d <= den;
      end else if (ucw.misc == MISC_DIV10) begin
        unique case (ucw.dst)
          DST_D:   d <= quo_ten;
          DST_K:   k <= quo_ten;
          default: r <= quo_ten;
        endcase
      end else if (ucw.misc == MISC_MUL) begin
        // product wraps mod 2^32
        p <= prod[WordW-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ctrl.step_go && (ucw.misc == MISC_EMIT || ucw.misc == MISC_EMIT_INV)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step_go && !ucw.is_div && ucw.misc == MISC_EMIT) begin
      rsp.duration_ticks <= p;
      rsp.invalid        <= 1'b0;
    end else if (ctrl.step_go && !ucw.is_div && ucw.misc == MISC_EMIT_INV) begin
      rsp.duration_ticks <= '0;
      rsp.invalid        <= 1'b1;
    end
  end

  // The divider is never restarted while it is working
  a_div_start_idle : assert property (@(posedge clk) disable iff (rst)
    ctrl.div_start |-> !div_busy)
    else $error("divider started while busy");

  // A completed divide always follows a busy period
  a_div_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    div_done |-> $past(div_busy))
    else $error("divider done without a preceding busy cycle");

  // An idle block has no divide in flight
  a_idle_div_quiet : assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !div_busy && !div_done)
    else $error("request taken while a divide is in flight");

  // An invalid result carries a zero duration
  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.invalid |-> rsp.duration_ticks == '0)
    else $error("invalid result with nonzero duration");

endmodule

// ----- tb/sv/tb_frame_duration_calc.sv -----
`timescale 1ns / 1ps
// Testbench for frame_duration_calc: predicted ticks and invalid flag checked under random flow control.
module tb_frame_duration_calc;
  import fdc_pkg::*;

  localparam int unsigned NumRandom   = 600;
  localparam int unsigned NumCorner   = 20;
  localparam int unsigned CycleLimit  = 6000000;
  localparam int unsigned LongHold    = 3000;
  localparam int unsigned HoldAt      = 20;
  localparam int unsigned DrainCycles = 200;

  typedef struct packed {
    logic [31:0] ticks;
    logic        bad;
  } frame_len_t;

  // Expected frame durations, oldest first, plus the predictor that fills them
  class duration_scoreboard;
    frame_len_t  pending_q[$];
    int unsigned n_req;
    int unsigned n_rsp;
    int unsigned n_invalid;
    int unsigned n_wrap;
    int unsigned n_scaled;
    int unsigned n_errors;

    function frame_len_t calc_duration(input logic [31:0] num, input logic [31:0] den);
      frame_len_t  res;
      logic [31:0] x, y, rem, k, r, bound, d;
      logic [63:0] wide;
      res.ticks = '0;
      res.bad   = 1'b1;
      if (num == 0 || den == 0) return res;
      // gcd of the tick rate and the numerator
      x = TICK_RATE;
      y = num;
      rem = x % y;
      while (rem != 0) begin
        x = y;
        y = rem;
        rem = x % y;
      end
      k = TICK_RATE / y;
      r = num / y;
      bound = FULL_WORD / k;
      d = den;
      // scale down by ten until the denominator copy fits or the factor runs out
      if (d > bound) n_scaled++;
      while (k != 0 && d > bound) begin
        d = d / SCALE_STEP;
        k = k / SCALE_STEP;
        r = r / SCALE_STEP;
      end
      if (r == 0) return res;
      // product wraps to 32 bits before the divide
      wide = {32'd0, k} * {32'd0, den};
      if (wide[63:32] != 0) n_wrap++;
      res.ticks = wide[31:0] / r;
      res.bad   = 1'b0;
      return res;
    endfunction

    function void note_request(input logic [31:0] num, input logic [31:0] den);
      n_req++;
      pending_q.push_back(calc_duration(num, den));
    endfunction

    function void check_result(input logic [31:0] ticks, input logic bad);
      frame_len_t want;
      n_rsp++;
      if (bad === 1'b1) n_invalid++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: duration_ticks=%0d invalid=%0b", ticks, bad);
        n_errors++;
        return;
      end
      want = pending_q.pop_front();
      if (ticks !== want.ticks) begin
        $error("duration_ticks: expected %0d, actual %0d", want.ticks, ticks);
        n_errors++;
      end
      if (bad !== want.bad) begin
        $error("invalid: expected %0b, actual %0b", want.bad, bad);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        no_idle = 1'b0;
  int unsigned cycle_count = 0;
  duration_scoreboard tracker;

  // Directed corners: zero inputs, collapsed divisor, factor hitting zero, wrap
  logic [31:0] corner_num [NumCorner] = '{
    32'd0, 32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF,
    32'd1, 32'd90000, 32'd1, 32'd1, 32'd7,
    32'hFFFF_FFFF, 32'd7000007, 32'd30000, 32'd24000, 32'd25,
    32'd60000, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 32'd12345
  };
  logic [31:0] corner_den [NumCorner] = '{
    32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0,
    32'd1, 32'd1, 32'd47721, 32'd47722, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'd477219, 32'd1001, 32'd1001, 32'd1,
    32'd1001, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000
  };
  logic [31:0] common_num [11] = '{
    32'd24000, 32'd30000, 32'd60000, 32'd25, 32'd30, 32'd50,
    32'd60, 32'd24, 32'd90000, 32'd48000, 32'd120
  };
  logic [31:0] common_den [6] = '{
    32'd1, 32'd1000, 32'd1001, 32'd1, 32'd100, 32'd3
  };

  fdc_req_if req_ch();
  fdc_rsp_if rsp_ch();

  frame_duration_calc DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL frame_duration_calc");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic offer_request(input logic [31:0] num, input logic [31:0] den);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.rate_numerator <= num;
    req_ch.rate_denominator <= den;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request(num, den);
  endtask

  // Result side: random stalls, one long hold-off to back up the request side
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && tracker.n_rsp == HoldAt) begin
        held = 1'b1;
        stall = LongHold;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      tracker.check_result(rsp_ch.duration_ticks, rsp_ch.invalid);
    end
  end

  // Stimulus
  initial begin
    logic [31:0] num, den;
    tracker = new();
    req_ch.valid <= 1'b0;
    req_ch.rate_numerator <= '0;
    req_ch.rate_denominator <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NumCorner; i++) offer_request(corner_num[i], corner_den[i]);

    // random rates: mostly nonzero, mixed magnitudes, with a stretch of no idling
    for (int i = 0; i < NumRandom; i++) begin
      no_idle <= (i >= 250 && i < 330);
      case ($urandom_range(0, 15))
        0:            num = '0;
        1, 2, 3, 4:   num = $urandom;
        5, 6, 7, 8:   num = $urandom_range(1, 200000);
        9, 10, 11, 12: num = common_num[$urandom_range(0, 10)];
        default:      num = $urandom >> $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 15))
        0:            den = '0;
        1, 2, 3, 4:   den = $urandom;
        5, 6, 7, 8:   den = $urandom_range(1, 2000);
        9, 10, 11, 12: den = common_den[$urandom_range(0, 5)];
        default:      den = $urandom >> $urandom_range(0, 31);
      endcase
      offer_request(num, den);
    end
    req_ch.valid <= 1'b0;

    while (tracker.pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d requests, %0d results: %0d invalid, %0d scaled by ten, %0d wrapped.",
             tracker.n_req, tracker.n_rsp, tracker.n_invalid, tracker.n_scaled, tracker.n_wrap);
    $display("Both sides idled 0-15 cycles per request; results held off once for %0d cycles.",
             LongHold);
    if (tracker.n_errors == 0) begin
      $display("PASS frame_duration_calc");
    end else begin
      $display("FAIL frame_duration_calc");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fdc_pkg.sv
rtl/fdc_req_if.sv
rtl/fdc_rsp_if.sv
rtl/fdc_div.sv
rtl/fdc_seq.sv
rtl/frame_duration_calc.sv
tb/sv/tb_frame_duration_calc.sv
